### rtl/b64d_pkg.sv
// Shared types, codes and the character classifier for the base64 stream decoder.
// Used by the front, queue, back and top-level modules; depends on nothing else.
package b64d_pkg;

    // Default widths and sizes handed to the top-level parameters.
    localparam int CNT_BITS_DEF    = 16;
    localparam int QUEUE_DEPTH_DEF = 4;

    // Fixed field widths of the stream channels and the capacity register.
    localparam int CHAR_W     = 8;
    localparam int BYTE_W     = 8;
    localparam int STATUS_W   = 3;
    localparam int OUT_CNT_W  = 16;
    localparam int CAP_W      = 16;
    localparam int M_TDATA_W  = 32;
    localparam logic [CAP_W-1:0] CAP_RESET = 16'hFFFF;

    // Payload status codes.
    localparam logic [STATUS_W-1:0] ST_OK             = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_CHAR       = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DATA_AFTER_PAD = 3'd2;
    localparam logic [STATUS_W-1:0] ST_MISPLACED_PAD  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_OVER_CAPACITY  = 3'd4;
    localparam logic [STATUS_W-1:0] ST_INCOMPLETE     = 3'd5;

    // Input item kinds and result kinds.
    localparam logic KIND_CHAR   = 1'b0;
    localparam logic KIND_END    = 1'b1;
    localparam logic RES_DATA    = 1'b0;
    localparam logic RES_STATUS  = 1'b1;

    // Character classes.
    typedef enum logic [1:0] {
        CH_SEXTET = 2'd0,
        CH_PAD    = 2'd1,
        CH_SPACE  = 2'd2,
        CH_BAD    = 2'd3
    } char_kind_t;

    typedef struct packed {
        char_kind_t  kind;
        logic [5:0]  sext;
    } char_info_t;

    // One unit of work for the back end: a status result or one to three bytes.
    typedef struct packed {
        logic                        is_end;
        logic [1:0]                  nb;
        logic [2:0][BYTE_W-1:0]      bytes;
        logic [STATUS_W-1:0]         status;
        logic [OUT_CNT_W-1:0]        count;
    } job_t;

    // Maps an ASCII code to its base64 class and sextet value.
    function automatic char_info_t classify(input logic [CHAR_W-1:0] c);
        char_info_t r;
        r.kind = CH_BAD;
        r.sext = '0;
        if (c >= 8'h41 && c <= 8'h5A) begin
            r.kind = CH_SEXTET;
            r.sext = 6'(c - 8'h41);
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            r.kind = CH_SEXTET;
            r.sext = 6'(c - 8'h61 + 8'd26);
        end else if (c >= 8'h30 && c <= 8'h39) begin
            r.kind = CH_SEXTET;
            r.sext = 6'(c - 8'h30 + 8'd52);
        end else if (c == 8'h2B) begin
            r.kind = CH_SEXTET;
            r.sext = 6'd62;
        end else if (c == 8'h2F) begin
            r.kind = CH_SEXTET;
            r.sext = 6'd63;
        end else if (c == 8'h3D) begin
            r.kind = CH_PAD;
        end else if (c == 8'h20 || (c >= 8'h09 && c <= 8'h0D)) begin
            r.kind = CH_SPACE;
        end
        return r;
    endfunction

endpackage

### rtl/b64d_front.sv
// Front end of the base64 decoder: accepts characters, tracks the group and error
// state, checks capacity and pushes byte or status jobs. Depends on b64d_pkg.
module b64d_front import b64d_pkg::*; #(
    parameter int COUNT_BITS = CNT_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CAP_W-1:0]     cfg_wdata,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic                 s_kind,
    input  logic [CHAR_W-1:0]    s_char,
    input  logic                 q_full,
    output logic                 push,
    output job_t                 push_job
);

    localparam int LW = (COUNT_BITS > CAP_W) ? COUNT_BITS : CAP_W;

    logic [CAP_W-1:0]      cap_reg, cap_next;
    logic [2:0][5:0]       sext_reg, sext_next;
    logic [2:0]            pm_reg, pm_next;
    logic [1:0]            fill_reg, fill_next;
    logic                  pad_seen_reg, pad_seen_next;
    logic [STATUS_W-1:0]   err_reg, err_next;
    logic [COUNT_BITS-1:0] cnt_reg, cnt_next;

    logic                  accept;
    char_info_t            info;
    logic                  is_pad;
    logic [5:0]            s3;
    logic [LW-1:0]         cap_w, max_w, limit, avail;
    logic [1:0]            avail_small;
    logic [1:0]            k;
    logic [1:0]            nb;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && !q_full;
    assign info     = classify(s_char);
    assign is_pad   = (info.kind == CH_PAD);
    assign s3       = is_pad ? 6'd0 : info.sext;

    // Room left under the capacity or the counter's largest value; none when the
    // count already sits at or above a lowered capacity.
    always_comb begin
        cap_w = LW'(cap_reg);
        max_w = LW'({COUNT_BITS{1'b1}});
        limit = (cap_w < max_w) ? cap_w : max_w;
        avail = (limit > LW'(cnt_reg)) ? (limit - LW'(cnt_reg)) : '0;
        avail_small = (avail >= LW'(3)) ? 2'd3 : avail[1:0];
    end

    // Number of bytes the completed group would give before capacity.
    always_comb begin
        if (pm_reg[0] || pm_reg[1]) begin
            k = 2'd0;
        end else if (pm_reg[2]) begin
            k = 2'd1;
        end else if (is_pad) begin
            k = 2'd2;
        end else begin
            k = 2'd3;
        end
        nb = (k < avail_small) ? k : avail_small;
    end

    // Capacity write, and group, error and count update per accepted item.
    always_comb begin
        cap_next      = cfg_we ? cfg_wdata : cap_reg;
        sext_next     = sext_reg;
        pm_next       = pm_reg;
        fill_next     = fill_reg;
        pad_seen_next = pad_seen_reg;
        err_next      = err_reg;
        cnt_next      = cnt_reg;
        push          = 1'b0;
        push_job      = '0;
        push_job.count = OUT_CNT_W'(cnt_reg);
        push_job.bytes[0] = {sext_reg[0], sext_reg[1][5:4]};
        push_job.bytes[1] = {sext_reg[1][3:0], sext_reg[2][5:2]};
        push_job.bytes[2] = {sext_reg[2][1:0], s3};
        if (accept) begin
            if (s_kind == KIND_END) begin
                push            = 1'b1;
                push_job.is_end = 1'b1;
                push_job.status = (err_reg == ST_OK && fill_reg != 2'd0) ?
                                  ST_INCOMPLETE : err_reg;
                sext_next       = '0;
                pm_next         = '0;
                fill_next       = 2'd0;
                pad_seen_next   = 1'b0;
                err_next        = ST_OK;
                cnt_next        = '0;
            end else if (err_reg == ST_OK) begin
                case (info.kind)
                    CH_BAD: begin
                        err_next = ST_BAD_CHAR;
                    end
                    CH_SPACE: begin
                        err_next = err_reg;
                    end
                    default: begin
                        if (!is_pad && pad_seen_reg) begin
                            err_next = ST_DATA_AFTER_PAD;
                        end else begin
                            if (is_pad) begin
                                pad_seen_next = 1'b1;
                            end
                            if (fill_reg != 2'd3) begin
                                sext_next[fill_reg] = s3;
                                pm_next[fill_reg]   = is_pad;
                                fill_next           = fill_reg + 2'd1;
                            end else begin
                                // Group of four complete.
                                fill_next   = 2'd0;
                                push        = (nb != 2'd0);
                                push_job.nb = nb;
                                cnt_next    = cnt_reg + COUNT_BITS'(nb);
                                if (pm_reg[0] || pm_reg[1]) begin
                                    err_next = ST_MISPLACED_PAD;
                                end else if (nb < k) begin
                                    err_next = ST_OVER_CAPACITY;
                                end else if (pm_reg[2] && !is_pad) begin
                                    err_next = ST_MISPLACED_PAD;
                                end
                            end
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg      <= CAP_RESET;
            sext_reg     <= '0;
            pm_reg       <= '0;
            fill_reg     <= 2'd0;
            pad_seen_reg <= 1'b0;
            err_reg      <= ST_OK;
            cnt_reg      <= '0;
        end else begin
            cap_reg      <= cap_next;
            sext_reg     <= sext_next;
            pm_reg       <= pm_next;
            fill_reg     <= fill_next;
            pad_seen_reg <= pad_seen_next;
            err_reg      <= err_next;
            cnt_reg      <= cnt_next;
        end
    end

endmodule

### rtl/b64d_queue.sv
// Short job queue between the decoder front and back ends.
// Register-based FIFO of job_t entries; depends on b64d_pkg.
module b64d_queue import b64d_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push,
    input  job_t  push_job,
    output logic  full,
    input  logic  pop,
    output logic  head_valid,
    output job_t  head_job
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    job_t            mem_reg [DEPTH];
    logic [PW-1:0]   wr_reg, wr_next;
    logic [PW-1:0]   rd_reg, rd_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic            do_pop;

    assign full       = (cnt_reg == CW'(DEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head_job   = mem_reg[rd_reg];
    assign do_pop     = pop && head_valid;

    // Pointer and fill count update.
    always_comb begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (push) begin
            wr_next = (wr_reg == PW'(DEPTH - 1)) ? '0 : wr_reg + PW'(1);
        end
        if (do_pop) begin
            rd_next = (rd_reg == PW'(DEPTH - 1)) ? '0 : rd_reg + PW'(1);
        end
        if (push && !do_pop) begin
            cnt_next = cnt_reg + CW'(1);
        end else if (!push && do_pop) begin
            cnt_next = cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_reg] <= push_job;
        end
    end

endmodule

### rtl/b64d_back.sv
// Back end of the base64 decoder: expands queued jobs into results, one per
// cycle when not stalled, via a registered output. Depends on b64d_pkg.
module b64d_back import b64d_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   head_valid,
    input  job_t                   head_job,
    output logic                   pop,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic                   m_kind,
    output logic [BYTE_W-1:0]      m_data,
    output logic [STATUS_W-1:0]    m_status,
    output logic [OUT_CNT_W-1:0]   m_count,
    output logic                   m_last
);

    job_t                   cur_reg, cur_next;
    logic                   cur_valid_reg, cur_valid_next;
    logic [1:0]             idx_reg, idx_next;
    logic                   ov_reg, ov_next;
    logic                   okind_reg, okind_next;
    logic [BYTE_W-1:0]      odata_reg, odata_next;
    logic [STATUS_W-1:0]    ostat_reg, ostat_next;
    logic [OUT_CNT_W-1:0]   ocnt_reg, ocnt_next;
    logic                   olast_reg, olast_next;

    logic                   out_free;
    logic                   cur_last;

    assign out_free = !ov_reg || m_tready;
    assign cur_last = cur_reg.is_end || (idx_reg == cur_reg.nb - 2'd1);
    assign pop      = head_valid && (!cur_valid_reg || (out_free && cur_last));

    // Result selection and job sequencing.
    always_comb begin
        cur_next       = cur_reg;
        cur_valid_next = cur_valid_reg;
        idx_next       = idx_reg;
        ov_next        = ov_reg && !m_tready;
        okind_next     = okind_reg;
        odata_next     = odata_reg;
        ostat_next     = ostat_reg;
        ocnt_next      = ocnt_reg;
        olast_next     = olast_reg;
        if (cur_valid_reg && out_free) begin
            ov_next    = 1'b1;
            olast_next = cur_last;
            if (cur_reg.is_end) begin
                okind_next = RES_STATUS;
                odata_next = '0;
                ostat_next = cur_reg.status;
                ocnt_next  = cur_reg.count;
            end else begin
                okind_next = RES_DATA;
                odata_next = cur_reg.bytes[idx_reg];
                ostat_next = ST_OK;
                ocnt_next  = cur_reg.count + OUT_CNT_W'(idx_reg) + OUT_CNT_W'(1);
            end
            idx_next = idx_reg + 2'd1;
            if (cur_last) begin
                cur_valid_next = 1'b0;
            end
        end
        if (pop) begin
            cur_next       = head_job;
            cur_valid_next = 1'b1;
            idx_next       = 2'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
            ov_reg        <= 1'b0;
        end else begin
            cur_valid_reg <= cur_valid_next;
            idx_reg       <= idx_next;
            ov_reg        <= ov_next;
        end
    end

    // Job and result payload registers.
    always_ff @(posedge aclk) begin
        cur_reg   <= cur_next;
        okind_reg <= okind_next;
        odata_reg <= odata_next;
        ostat_reg <= ostat_next;
        ocnt_reg  <= ocnt_next;
        olast_reg <= olast_next;
    end

    assign m_tvalid = ov_reg;
    assign m_kind   = okind_reg;
    assign m_data   = odata_reg;
    assign m_status = ostat_reg;
    assign m_count  = ocnt_reg;
    assign m_last   = olast_reg;

endmodule

### rtl/base64_stream_decoder.sv
// Top level of the streaming base64 decoder: connects front end, job queue and back end.
// Depends on b64d_pkg, b64d_front, b64d_queue and b64d_back.
//
// The decoder takes one character or end request per cycle as long as its job queue
// has room. Each group of four base64 symbols gives at most three byte requests, and
// each end request gives one status request carrying the payload status and byte
// count; the back end sends one result per cycle, unless m_tready stalls it, through
// a registered output while the front end keeps accepting. The user must write capacity
// through cfg_we/cfg_wdata only while the decoder is idle; the block does not enforce
// this. Capacity survives end requests. Bytes of a payload whose final status is not
// zero are to be discarded.
module base64_stream_decoder import b64d_pkg::*; #(
    parameter int COUNT_BITS  = CNT_BITS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CAP_W-1:0]      cfg_wdata,    // capacity
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [CHAR_W-1:0]     s_tdata,      // [7:0] char_byte
    input  logic [0:0]            s_tuser,      // [0] kind
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,      // [7:0] data_byte, [10:8] status,
                                                // [26:11] byte_count, [31:27] zero
    output logic [0:0]            m_tuser,      // [0] result_kind
    output logic                  m_tlast       // last_of_run
);

    logic                  q_full;
    logic                  push;
    job_t                  push_job;
    logic                  pop;
    logic                  head_valid;
    job_t                  head_job;
    logic                  m_kind;
    logic [BYTE_W-1:0]     m_data;
    logic [STATUS_W-1:0]   m_status;
    logic [OUT_CNT_W-1:0]  m_count;

    b64d_front #(
        .COUNT_BITS (COUNT_BITS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_kind    (s_tuser[0]),
        .s_char    (s_tdata),
        .q_full    (q_full),
        .push      (push),
        .push_job  (push_job)
    );

    b64d_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_job   (push_job),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    b64d_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_kind     (m_kind),
        .m_data     (m_data),
        .m_status   (m_status),
        .m_count    (m_count),
        .m_last     (m_tlast)
    );

    // Pack the result fields, lowest field first.
    assign m_tdata    = {5'd0, m_count, m_status, m_data};
    assign m_tuser[0] = m_kind;

endmodule

### test/tb_top.sv
// Self-checking testbench for the base64 stream decoder: directed and random payloads,
// a per-request decoder model and an in-order result checker with random stalls.
// Depends on b64d_pkg and base64_stream_decoder.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import b64d_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 8;
    localparam logic [CHAR_W-1:0] PAD_CHAR   = 8'h3D;
    localparam logic [CHAR_W-1:0] SPACE_CHAR = 8'h20;
    localparam logic [CHAR_W-1:0] TAB_CHAR   = 8'h09;
    localparam logic [CHAR_W-1:0] HIGH_CHAR  = 8'hFF;

    // One request on the character channel.
    typedef struct packed {
        logic              kind;
        logic [CHAR_W-1:0] ch;
    } text_req_t;

    // One result as the decoder should deliver it.
    typedef struct packed {
        logic                 kind;
        logic [BYTE_W-1:0]    data;
        logic [STATUS_W-1:0]  status;
        logic [OUT_CNT_W-1:0] count;
        logic                 last;
    } dec_result_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CAP_W-1:0]     cfg_wdata = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [CHAR_W-1:0]    s_tdata   = '0;
    logic [0:0]           s_tuser   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [0:0]           m_tuser;
    logic                 m_tlast;

    base64_stream_decoder DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // Requests waiting to be sent and results the decoder still owes.
    text_req_t   char_feed[$];
    dec_result_t decoded_due[$];
    dec_result_t head_due;
    text_req_t   head_req;

    int  issued_cnt     = 0;
    int  accepted_cnt   = 0;
    int  fed_count      = 0;
    int  fail_count     = 0;
    int  bytes_checked  = 0;
    int  status_checked = 0;
    int  cap_writes     = 0;
    int  cycle_count    = 0;
    int  send_hold      = 0;
    int  recv_hold      = 0;
    bit  idle_on        = 1'b1;

    // Decoder model state and its copy of the capacity register.
    int                  cap_model = 65535;
    logic [5:0]          sext_held[3];
    logic                pad_held[3];
    int                  group_fill;
    bit                  pad_seen;
    logic [STATUS_W-1:0] fault_code;
    int                  bytes_out;

    always #6 aclk = ~aclk;

    always @(posedge aclk) cycle_count++;

    // Returns the base64 class of a character and, for data symbols, its value.
    function automatic void sort_char(input logic [CHAR_W-1:0] c, output char_kind_t cls,
                                      output logic [5:0] val);
        val = '0;
        cls = CH_BAD;
        if (c >= "A" && c <= "Z") begin
            cls = CH_SEXTET;
            val = 6'(c - "A");
        end else if (c >= "a" && c <= "z") begin
            cls = CH_SEXTET;
            val = 6'(c - "a" + 26);
        end else if (c >= "0" && c <= "9") begin
            cls = CH_SEXTET;
            val = 6'(c - "0" + 52);
        end else if (c == "+") begin
            cls = CH_SEXTET;
            val = 6'd62;
        end else if (c == "/") begin
            cls = CH_SEXTET;
            val = 6'd63;
        end else if (c == PAD_CHAR) begin
            cls = CH_PAD;
        end else if (c == SPACE_CHAR || (c >= TAB_CHAR && c <= 8'h0D)) begin
            cls = CH_SPACE;
        end
    endfunction

    function automatic void clear_payload();
        for (int i = 0; i < 3; i++) begin
            sext_held[i] = '0;
            pad_held[i]  = 1'b0;
        end
        group_fill = 0;
        pad_seen   = 1'b0;
        fault_code = ST_OK;
        bytes_out  = 0;
    endfunction

    // Works out the results one accepted request causes and queues them.
    task automatic decode_model(input logic kind, input logic [CHAR_W-1:0] ch);
        char_kind_t           cls;
        logic [5:0]           sym;
        logic [2:0][7:0]      grp;
        logic [7:0]           got_byte[3];
        logic [OUT_CNT_W-1:0] got_cnt[3];
        logic [STATUS_W-1:0]  st;
        int                   n_out;
        int                   n_want;
        int                   i;
        bit                   is_pad;
        n_out = 0;
        if (kind == KIND_END) begin
            st = fault_code;
            if (st == ST_OK && group_fill != 0) st = ST_INCOMPLETE;
            decoded_due.push_back('{RES_STATUS, 8'h00, st, OUT_CNT_W'(bytes_out), 1'b1});
            clear_payload();
            return;
        end
        // After the first fault every character is dropped until the end request.
        if (fault_code != ST_OK) return;
        sort_char(ch, cls, sym);
        if (cls == CH_SPACE) return;
        if (cls == CH_BAD) begin
            fault_code = ST_BAD_CHAR;
            return;
        end
        is_pad = (cls == CH_PAD);
        if (is_pad) begin
            pad_seen = 1'b1;
            sym = '0;
        end else if (pad_seen) begin
            fault_code = ST_DATA_AFTER_PAD;
            return;
        end
        if (group_fill < 3) begin
            sext_held[group_fill] = sym;
            pad_held[group_fill]  = is_pad;
            group_fill++;
            return;
        end
        // Fourth symbol: the group is complete.
        group_fill = 0;
        if (pad_held[0] || pad_held[1]) begin
            fault_code = ST_MISPLACED_PAD;
            return;
        end
        grp[0] = {sext_held[0], sext_held[1][5:4]};
        grp[1] = {sext_held[1][3:0], sext_held[2][5:2]};
        grp[2] = {sext_held[2][1:0], sym};
        n_want = pad_held[2] ? 1 : (is_pad ? 2 : 3);
        for (i = 0; i < n_want; i++) begin
            if (fault_code == ST_OK) begin
                if (bytes_out + 1 > cap_model) begin
                    fault_code = ST_OVER_CAPACITY;
                end else begin
                    bytes_out++;
                    got_byte[n_out] = grp[i];
                    got_cnt[n_out]  = OUT_CNT_W'(bytes_out);
                    n_out++;
                end
            end
        end
        if (pad_held[2] && !is_pad && fault_code == ST_OK) fault_code = ST_MISPLACED_PAD;
        for (i = 0; i < n_out; i++) begin
            decoded_due.push_back('{RES_DATA, got_byte[i], ST_OK, got_cnt[i], i == n_out - 1});
        end
    endtask

    function automatic int field_diff(input string name, input int want, input int got);
        if (want == got) return 0;
        $error("%s mismatch: expected %0d, actual %0d", name, want, got);
        return 1;
    endfunction

    // Monitor: model each accepted request, check each accepted result in order.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                decode_model(s_tuser[0], s_tdata);
                accepted_cnt++;
            end
            if (m_tvalid && m_tready) begin
                if (decoded_due.size() == 0) begin
                    $error("result with nothing expected: tdata %h, tuser %b, tlast %b",
                           m_tdata, m_tuser, m_tlast);
                    fail_count++;
                end else begin
                    head_due = decoded_due.pop_front();
                    fail_count += field_diff("result_kind", head_due.kind, m_tuser[0]);
                    fail_count += field_diff("data_byte", head_due.data, m_tdata[7:0]);
                    fail_count += field_diff("status", head_due.status, m_tdata[10:8]);
                    fail_count += field_diff("byte_count", head_due.count, m_tdata[26:11]);
                    fail_count += field_diff("last_of_run", head_due.last, m_tlast);
                    if (head_due.kind == RES_STATUS) status_checked++;
                    else bytes_checked++;
                end
            end
        end
    end

    // Driver: hold a request until it is taken, then send the next or pause.
    always @(negedge aclk) begin
        if (aresetn && accepted_cnt == issued_cnt) begin
            if (send_hold > 0) begin
                send_hold--;
                s_tvalid <= 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                send_hold = $urandom_range(1, 19) - 1;
                s_tvalid <= 1'b0;
            end else if (char_feed.size() != 0) begin
                head_req = char_feed.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= head_req.kind;
                s_tdata  <= head_req.ch;
                issued_cnt++;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Result side back-pressure in random bursts.
    always @(negedge aclk) begin
        if (recv_hold > 0) begin
            recv_hold--;
            m_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            recv_hold = $urandom_range(1, 19) - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic feed_char(input logic [CHAR_W-1:0] c);
        char_feed.push_back('{KIND_CHAR, c});
        fed_count++;
    endtask

    task automatic feed_end();
        char_feed.push_back('{KIND_END, CHAR_W'($urandom_range(0, 255))});
        fed_count++;
    endtask

    task automatic feed_text(input string txt);
        for (int i = 0; i < txt.len(); i++) feed_char(txt[i]);
    endtask

    function automatic logic [CHAR_W-1:0] b64_symbol(input logic [5:0] v);
        if (v < 26) return CHAR_W'("A" + v);
        if (v < 52) return CHAR_W'("a" + v - 26);
        if (v < 62) return CHAR_W'("0" + v - 52);
        return (v == 62) ? "+" : "/";
    endfunction

    function automatic logic [CHAR_W-1:0] random_space();
        int pick;
        pick = $urandom_range(0, 5);
        return (pick == 5) ? SPACE_CHAR : CHAR_W'(TAB_CHAR + pick);
    endfunction

    // Mostly well-formed encoded payloads with random bytes; the rest is noise.
    task automatic feed_random_payload();
        logic [23:0] chunk;
        int          n_raw;
        int          n_sym;
        int          i;
        int          k;
        int          pick;
        bit          keep_pads;
        if ($urandom_range(0, 9) < 7) begin
            n_raw = $urandom_range(0, 9);
            keep_pads = ($urandom_range(0, 3) != 0);
            for (i = 0; i < n_raw; i += 3) begin
                chunk = 24'($urandom);
                n_sym = ((n_raw - i) >= 3 ? 3 : (n_raw - i)) + 1;
                for (k = 0; k < 4; k++) begin
                    if ($urandom_range(0, 7) == 0) feed_char(random_space());
                    if (k < n_sym) feed_char(b64_symbol(chunk[23 - 6 * k -: 6]));
                    else if (keep_pads) feed_char(PAD_CHAR);
                end
            end
        end else begin
            n_raw = $urandom_range(1, 10);
            for (i = 0; i < n_raw; i++) begin
                pick = $urandom_range(0, 19);
                if (pick < 10) feed_char(b64_symbol(6'($urandom)));
                else if (pick < 14) feed_char(PAD_CHAR);
                else if (pick < 17) feed_char(random_space());
                else feed_char(8'($urandom));
            end
        end
        feed_end();
    endtask

    task automatic feed_random_items(input int n);
        int goal;
        goal = fed_count + n;
        while (fed_count < goal) feed_random_payload();
    endtask

    // Waits until every request is taken and every result has arrived.
    task automatic wait_drained();
        while (char_feed.size() != 0 || accepted_cnt != issued_cnt || decoded_due.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // Capacity is only written while the decoder is idle.
    task automatic set_capacity(input int cap);
        cfg_we    <= 1'b1;
        cfg_wdata <= CAP_W'(cap);
        cap_model = cap;
        cap_writes++;
        @(negedge aclk);
        cfg_we <= 1'b0;
        @(negedge aclk);
    endtask

    // Run out of time: report and stop.
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles", cycle_count);
        $display("tb_top: done, errors");
        $finish;
    end

    initial begin
        clear_payload();
        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: alphabet edges, whitespace, a padded group, each fault but over capacity.
        feed_text("\t+/09\r");
        feed_end();
        feed_text("Az==");
        feed_end();
        feed_char(HIGH_CHAR);
        feed_end();
        feed_text("A===");
        feed_end();
        feed_text("QQ=A");
        feed_end();
        feed_text("AB");
        feed_end();
        feed_end();
        wait_drained();

        // Capacity runs out inside a group.
        set_capacity(2);
        feed_text("TWFu");
        feed_end();
        feed_random_items(18);
        wait_drained();

        // No bytes allowed at all.
        set_capacity(0);
        feed_text("TQ==");
        feed_end();
        feed_random_items(10);
        wait_drained();

        set_capacity($urandom_range(1, 8));
        feed_random_items(22);
        wait_drained();

        // Full capacity and a stretch without any pauses.
        set_capacity(65535);
        idle_on = 1'b0;
        feed_random_items(22);
        wait_drained();

        $display("%0d requests sent over %0d capacity settings", fed_count, cap_writes);
        $display("%0d data bytes and %0d payload statuses checked", bytes_checked,
                 status_checked);
        if (fail_count == 0 && decoded_due.size() == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule
